// ----- sv/saws_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// saws_pkg: shared types and constants for the self-avoiding walk step core
// Point and token types, outcome and register codes, and the bounded
// lattice step used to form a candidate point.
// ----------------------------------------------------------------------------
package saws_pkg;

  // lattice geometry
  localparam int COORD_W = 9;
  localparam int DIMS    = 2;

  typedef logic [COORD_W-1:0] coord_t;
  typedef coord_t [DIMS-1:0]  point_t;

  // rejection counter
  localparam int                REJECT_W     = 4;
  localparam logic [REJECT_W-1:0] REJECT_LIMIT = 4'd10;

  // configuration register indexes
  localparam int                CFG_IDX_W       = 2;
  localparam logic [CFG_IDX_W-1:0] REG_COORD_MIN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COORD_MAX   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WALK_LENGTH = 2'd2;

  // configuration reset values
  localparam coord_t COORD_MIN_RESET   = 9'd0;
  localparam coord_t COORD_MAX_RESET   = 9'd500;
  localparam coord_t WALK_LENGTH_RESET = 9'd200;

  // result codes
  typedef enum logic [1:0] {
    OUT_ACCEPTED  = 2'd0,
    OUT_COLLISION = 2'd1,
    OUT_RESTART   = 2'd2,
    OUT_IDLE_DONE = 2'd3
  } outcome_t;

  // search token passed along the cell chain
  typedef struct packed {
    logic valid;
    logic hit;
  } token_t;

  // one step of one coordinate, reflecting at the bounds
  function automatic coord_t step_coord(coord_t p, logic down, coord_t lo, coord_t hi);
    coord_t dec;
    coord_t inc;
    logic   dec_ok;
    logic   inc_ok;
    dec    = p - 1'b1;
    inc    = p + 1'b1;
    dec_ok = (p != '0) && (dec >= lo);
    inc_ok = (p != '1) && (inc <= hi);
    if (down) begin
      return dec_ok ? dec : inc;
    end else begin
      return inc_ok ? inc : dec;
    end
  endfunction

endpackage

// ----- sv/saws_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// saws_cell: one stored point of the walk
// Holds one lattice point, shifts it on to the next cell when a new point
// enters the chain, and checks the passing search token against the
// broadcast candidate.
// ----------------------------------------------------------------------------
module saws_cell
  import saws_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   load,
  input  point_t point_in,
  input  point_t cand,
  input  logic   active,
  input  token_t tok_in,
  output point_t point,
  output token_t tok_out
);

  // stored point, loaded from the previous cell on a shift
  always_ff @(posedge clk) begin
    if (load) begin
      point <= point_in;
    end
  end

  // search token, picks up a hit where this point matches the candidate
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out.valid <= tok_in.valid;
      tok_out.hit   <= tok_in.hit | (tok_in.valid & active & (point == cand));
    end
  end

endmodule

// ----- sv/self_avoiding_walk_step_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// self_avoiding_walk_step_core: self-avoiding lattice walk, one trial per beat
// The walk is kept in a row of MAX_POINTS cells with the newest point in the
// first cell; an accepted point shifts the row by one. A step beat forms a
// diagonal candidate from the newest point, then a search token walks the
// whole row, one cell per cycle, to look for a repeat, then the push state
// loads the result into the output register. A start beat, or a step beat on
// a finished walk, goes straight to the push state. One beat is worked on at
// a time; a finished result waits in the output register while the next beat
// is taken. The user must write the registers through the plain write port
// (index 0 coord_min, 1 coord_max, 2 walk_length) only while the core is
// idle, not enforced by the core. After reset the walk holds the origin alone.
// ----------------------------------------------------------------------------
module self_avoiding_walk_step_core
  import saws_pkg::*;
#(
  parameter int MAX_POINTS = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_data,
  // step beats
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 action,
  input  logic [DIMS-1:0]      step_down_mask,
  // result beats
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           outcome,
  output logic [7:0]           point_index,
  output logic [COORD_W-1:0]   coord_first,
  output logic [COORD_W-1:0]   coord_second,
  output logic                 walk_done
);

  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int LEN_W = (CNT_W > COORD_W) ? CNT_W : COORD_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_PUSH
  } state_t;

  state_t              state;
  coord_t              coord_min;
  coord_t              coord_max;
  coord_t              walk_length;
  logic [CNT_W-1:0]    points_stored;
  logic [REJECT_W-1:0] reject_count;
  logic                done_flag;
  logic                inject;
  point_t              cand;
  point_t              cand_next;
  outcome_t            res_outcome;

  logic                in_accept;
  logic                search_end;
  logic                shift_en;
  logic                origin_en;
  logic                cell0_load;
  point_t              cell0_in;
  token_t              tok_end;

  logic [LEN_W-1:0]    len_ext;
  logic [LEN_W-1:0]    max_ext;
  logic [LEN_W-1:0]    eff_len;
  logic [LEN_W-1:0]    ps_ext;
  logic [LEN_W-1:0]    ps_inc_ext;
  logic                at_end;
  logic                start_done;
  logic [CNT_W-1:0]    last_idx;
  logic [CNT_W+7:0]    idx_wide;

  point_t              chain_point [MAX_POINTS];
  token_t              chain_tok   [MAX_POINTS+1];
  logic [MAX_POINTS-1:0] cell_active;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      coord_min   <= COORD_MIN_RESET;
      coord_max   <= COORD_MAX_RESET;
      walk_length <= WALK_LENGTH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COORD_MIN:   coord_min   <= cfg_data;
        REG_COORD_MAX:   coord_max   <= cfg_data;
        REG_WALK_LENGTH: walk_length <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective walk length and end checks
  assign len_ext    = LEN_W'(walk_length);
  assign max_ext    = LEN_W'(MAX_POINTS);
  assign eff_len    = (len_ext > max_ext) ? max_ext : len_ext;
  assign ps_ext     = LEN_W'(points_stored);
  assign ps_inc_ext = ps_ext + LEN_W'(1);
  assign at_end     = ps_ext >= eff_len;
  assign start_done = eff_len <= LEN_W'(1);

  // candidate from the newest point, held in the first cell
  always_comb begin
    for (int d = 0; d < DIMS; d++) begin
      cand_next[d] = step_coord(chain_point[0][d], step_down_mask[d], coord_min, coord_max);
    end
  end

  // handshake and chain control
  assign in_stall   = (state != S_IDLE);
  assign in_accept  = in_valid && !in_stall;
  assign tok_end    = chain_tok[MAX_POINTS];
  assign search_end = (state == S_SEARCH) && tok_end.valid;
  assign shift_en   = search_end && !tok_end.hit;
  assign origin_en  = (in_accept && action) ||
                      (search_end && tok_end.hit && (reject_count == REJECT_LIMIT));
  assign cell0_load = rst || origin_en || shift_en;
  assign cell0_in   = (rst || origin_en) ? '0 : cand;

  assign chain_tok[0] = '{valid: inject, hit: 1'b0};

  // row of cells, newest point first
  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
    assign cell_active[i] = (CNT_W'(i) < points_stored);
    if (i == 0) begin : g_head
      saws_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .load     (cell0_load),
        .point_in (cell0_in),
        .cand     (cand),
        .active   (cell_active[i]),
        .tok_in   (chain_tok[i]),
        .point    (chain_point[i]),
        .tok_out  (chain_tok[i+1])
      );
    end else begin : g_body
      saws_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .load     (shift_en),
        .point_in (chain_point[i-1]),
        .cand     (cand),
        .active   (cell_active[i]),
        .tok_in   (chain_tok[i]),
        .point    (chain_point[i]),
        .tok_out  (chain_tok[i+1])
      );
    end
  end

  // index of the newest stored point
  assign last_idx = points_stored - CNT_W'(1);
  assign idx_wide = {8'd0, last_idx};

  // sequencer, walk state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      inject        <= 1'b0;
      out_valid     <= 1'b0;
      points_stored <= CNT_W'(1);
      reject_count  <= '0;
      done_flag     <= 1'b0;
    end else begin
      // search token launch for a step beat on an unfinished walk
      inject <= (state == S_IDLE) && in_accept && !action && !(done_flag || at_end);
      if (out_valid && !out_stall && (state != S_PUSH)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            if (action) begin
              points_stored <= CNT_W'(1);
              reject_count  <= '0;
              done_flag     <= start_done;
              res_outcome   <= OUT_IDLE_DONE;
              cand          <= '0;
              state         <= S_PUSH;
            end else if (done_flag || at_end) begin
              done_flag   <= 1'b1;
              res_outcome <= OUT_IDLE_DONE;
              cand        <= '0;
              state       <= S_PUSH;
            end else begin
              cand   <= cand_next;
              state  <= S_SEARCH;
            end
          end
        end
        S_SEARCH: begin
          if (tok_end.valid) begin
            if (!tok_end.hit) begin
              points_stored <= points_stored + CNT_W'(1);
              if (ps_inc_ext >= eff_len) begin
                done_flag <= 1'b1;
              end
              res_outcome <= OUT_ACCEPTED;
            end else if (reject_count == REJECT_LIMIT) begin
              reject_count  <= '0;
              points_stored <= CNT_W'(1);
              res_outcome   <= OUT_RESTART;
            end else begin
              reject_count <= reject_count + REJECT_W'(1);
              res_outcome  <= OUT_COLLISION;
            end
            state <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (!out_valid || !out_stall) begin
            out_valid    <= 1'b1;
            outcome      <= res_outcome;
            point_index  <= idx_wide[7:0];
            coord_first  <= cand[0];
            coord_second <= cand[1];
            walk_done    <= done_flag;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
